[design/vector_unit_pair_decoder_core_defines.svh]
// Assertion macros for the pair decoder core.
`ifndef VECTOR_UNIT_PAIR_DECODER_CORE_DEFINES_SVH
`define VECTOR_UNIT_PAIR_DECODER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VUPD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VUPD_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VUPD_ASSERT(label, clk, rst_n, prop, msg)
`define VUPD_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

[design/vupd_pkg.sv]
// ----------------------------------------------------------------------------
// vupd_pkg
// Types, codes and constants of the pair decoder.
// ----------------------------------------------------------------------------
package vupd_pkg;
    localparam logic [3:0] OP_MADD       = 4'd0;
    localparam logic [3:0] OP_MUL        = 4'd1;
    localparam logic [3:0] OP_LOADFLOAT  = 4'd2;
    localparam logic [3:0] OP_LQI        = 4'd3;
    localparam logic [3:0] OP_SQI        = 4'd4;
    localparam logic [3:0] OP_ADDIMM     = 4'd5;
    localparam logic [3:0] OP_LOADCONST  = 4'd6;
    localparam logic [3:0] OP_MOVE       = 4'd7;
    localparam logic [3:0] OP_JUMP       = 4'd8;
    localparam logic [3:0] OP_JAL        = 4'd9;
    localparam logic [3:0] OP_JR         = 4'd10;
    localparam logic [3:0] OP_STOP       = 4'd11;
    localparam logic [3:0] OP_BADOP      = 4'd12;
    localparam logic [3:0] OP_DELAYFAULT = 4'd13;
    localparam logic [3:0] OP_BUBBLE     = 4'd14;

    localparam logic [1:0] DS_REG = 2'd0;
    localparam logic [1:0] DS_ACC = 2'd1;
    localparam logic [1:0] DS_I   = 2'd2;

    localparam logic [31:0] MOVE_VF0_WORD = 32'h8000_033C;
    localparam logic [6:0]  LO_IADDIU = 7'h08;
    localparam logic [6:0]  LO_B      = 7'h20;
    localparam logic [6:0]  LO_BAL    = 7'h21;
    localparam logic [6:0]  LO_JR     = 7'h24;
    localparam logic [6:0]  SP_LQI    = 7'h34;
    localparam logic [6:0]  SP_SQI    = 7'h35;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [3:0]  op;
        logic [4:0]  dest_reg;
        logic [1:0]  dest_special;
        logic [31:0] source_value;
        logic [15:0] source2_value;
        logic [1:0]  broadcast_sel;
        logic [3:0]  field_mask;
        logic [31:0] target_addr;
        logic [28:0] link_value;
        logic        last_of_pair;
        logic        block_done;
    } t_uop;

    typedef struct packed {
        logic [31:0] upper_word;
        logic [31:0] lower_word;
        logic [31:0] pc;
    } t_pair;

    // classified pair: up to three slots with valid bits
    typedef struct packed {
        logic [2:0] vld;
        t_uop [2:0] slot;
    } t_entry;
endpackage

[design/vupd_if.sv]
// ----------------------------------------------------------------------------
// vupd_in_if / vupd_out_if
// Valid/ready channels of the pair decoder.
// ----------------------------------------------------------------------------
interface vupd_in_if;
    import vupd_pkg::*;
    logic  valid;
    logic  ready;
    t_pair data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vupd_out_if;
    import vupd_pkg::*;
    logic valid;
    logic ready;
    t_uop data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/vupd_front.sv]
// ----------------------------------------------------------------------------
// vupd_front
// Accepts pairs, decodes them into up to three micro-ops, tracks block state.
// ----------------------------------------------------------------------------
module vupd_front
    import vupd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    vupd_in_if.sink      in_ch,
    input  logic         i_q_full,
    output logic         o_push,
    output t_entry       o_entry
);
    logic r_delay_pending, n_delay_pending;
    logic r_end_seen, n_end_seen;

    t_uop        u_up, u_lo, u_st;
    logic        up_ok, up_has, lo_ok, lo_has, lo_jmp;
    logic [5:0]  uop6;
    logic [6:0]  us, ls;
    logic [31:0] uw, lw, pc, rel;
    logic [14:0] imm;
    logic        fault;
    logic [3:0]  fcode;
    logic        done;

    assign uw = in_ch.data.upper_word;
    assign lw = in_ch.data.lower_word;
    assign pc = in_ch.data.pc;
    assign in_ch.ready = !i_q_full;
    assign o_push = in_ch.valid && !i_q_full;
    assign done = r_delay_pending;

    assign uop6 = uw[5:0];
    assign us = {uw[10:6], uw[1:0]};
    assign ls = {lw[10:6], lw[1:0]};
    assign rel = pc + {{18{lw[10]}}, lw[10:0], 3'b000} + 32'd8;
    assign imm = {lw[24:21], lw[10:0]};

    always_comb begin
        u_up = '0;
        up_ok = 1'b1;
        up_has = 1'b1;
        if (uop6 >= 6'h3C) begin
            if (us == 7'h2F || us == 7'h30) begin
                up_has = 1'b0;
            end else if (us >= 7'h08 && us <= 7'h0B) begin
                u_up.op = OP_MADD;
            end else if (us >= 7'h18 && us <= 7'h1B) begin
                u_up.op = OP_MUL;
            end else begin
                up_ok = 1'b0;
            end
            u_up.dest_special = DS_ACC;
        end else begin
            if (uop6 >= 6'h08 && uop6 <= 6'h0B) begin
                u_up.op = OP_MADD;
            end else if (uop6 >= 6'h18 && uop6 <= 6'h1B) begin
                u_up.op = OP_MUL;
            end else begin
                up_ok = 1'b0;
            end
            u_up.dest_reg = uw[10:6];
        end
        u_up.source_value  = {27'd0, uw[15:11]};
        u_up.source2_value = {11'd0, uw[20:16]};
        u_up.broadcast_sel = uw[1:0];
        u_up.field_mask    = uw[24:21];
        if (!up_ok) up_has = 1'b0;
    end

    always_comb begin
        u_lo = '0;
        lo_ok = 1'b1;
        lo_has = 1'b1;
        lo_jmp = 1'b0;
        if (uw[31]) begin
            u_lo.op = OP_LOADFLOAT;
            u_lo.dest_special = DS_I;
            u_lo.source_value = lw;
        end else if (lw[31]) begin
            u_lo.field_mask = lw[24:21];
            if (lw == MOVE_VF0_WORD) begin
                lo_has = 1'b0;
            end else if (lw[5:0] < 6'h3C) begin
                lo_ok = 1'b0;
            end else if (ls == SP_LQI) begin
                u_lo.op = OP_LQI;
                u_lo.dest_reg = lw[20:16];
                u_lo.source2_value = {11'd0, lw[15:11]};
            end else if (ls == SP_SQI) begin
                u_lo.op = OP_SQI;
                u_lo.source_value = {27'd0, lw[15:11]};
                u_lo.source2_value = {11'd0, lw[20:16]};
            end else begin
                lo_ok = 1'b0;
            end
        end else begin
            unique case (lw[31:25])
                LO_IADDIU: begin
                    if (lw[14:11] == lw[19:16]) begin
                        u_lo.op = OP_MOVE;
                        u_lo.source_value = {28'd0, lw[14:11]};
                    end else if (lw[14:11] == 4'd0) begin
                        u_lo.op = OP_LOADCONST;
                        u_lo.source_value = {17'd0, imm};
                    end else begin
                        u_lo.op = OP_ADDIMM;
                        u_lo.source_value = {28'd0, lw[14:11]};
                    end
                    u_lo.dest_reg = {1'b0, lw[19:16]};
                    u_lo.source2_value = {1'b0, imm};
                end
                LO_B: begin
                    u_lo.op = OP_JUMP;
                    u_lo.target_addr = rel;
                    lo_jmp = 1'b1;
                end
                LO_BAL: begin
                    u_lo.op = OP_JAL;
                    u_lo.target_addr = rel;
                    u_lo.link_value = 29'((pc + 32'd16) >> 3);
                    u_lo.dest_reg = {1'b0, lw[19:16]};
                    lo_jmp = 1'b1;
                end
                LO_JR: begin
                    u_lo.op = OP_JR;
                    u_lo.source_value = {28'd0, lw[14:11]};
                    lo_jmp = 1'b1;
                end
                default: begin
                    lo_ok = 1'b0;
                    lo_has = 1'b0;
                end
            endcase
        end
        if (!lo_ok) lo_has = 1'b0;
    end

    always_comb begin
        logic dp;
        logic [2:0] v;
        dp = r_delay_pending;
        v = 3'b000;
        fault = 1'b0;
        fcode = OP_BADOP;
        n_delay_pending = r_delay_pending;
        n_end_seen = r_end_seen;
        u_st = '0;
        u_st.op = OP_STOP;
        u_st.target_addr = pc + 32'd8;
        if (!up_ok || !lo_ok) begin
            fault = 1'b1;
        end else begin
            if (lo_jmp) begin
                if (dp) begin
                    fault = 1'b1;
                    fcode = OP_DELAYFAULT;
                end
                dp = 1'b1;
            end
            if (!fault && uw[30]) begin
                n_end_seen = 1'b1;
                if (dp) begin
                    fault = 1'b1;
                    fcode = OP_DELAYFAULT;
                end
                dp = 1'b1;
            end
            n_delay_pending = dp;
        end
        o_entry = '0;
        if (fault) begin
            n_delay_pending = 1'b0;
            n_end_seen = 1'b0;
            o_entry.vld = 3'b001;
            o_entry.slot[0].op = fcode;
            o_entry.slot[0].last_of_pair = 1'b1;
            o_entry.slot[0].block_done = 1'b1;
        end else begin
            v = {!uw[30] && r_end_seen, lo_has, up_has};
            o_entry.slot[0] = u_up;
            o_entry.slot[1] = u_lo;
            o_entry.slot[2] = u_st;
            if (v == 3'b000) begin
                v = 3'b001;
                o_entry.slot[0] = '0;
                o_entry.slot[0].op = OP_BUBBLE;
            end
            o_entry.vld = v;
            for (int k = 0; k < 3; k++) begin
                o_entry.slot[k].block_done = done;
            end
            if (v[2]) o_entry.slot[2].last_of_pair = 1'b1;
            else if (v[1]) o_entry.slot[1].last_of_pair = 1'b1;
            else o_entry.slot[0].last_of_pair = 1'b1;
            if (done) begin
                n_delay_pending = 1'b0;
                n_end_seen = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_pending <= 1'b0;
            r_end_seen <= 1'b0;
        end else if (o_push) begin
            r_delay_pending <= n_delay_pending;
            r_end_seen <= n_end_seen;
        end
    end
endmodule

[design/vupd_queue.sv]
// ----------------------------------------------------------------------------
// vupd_queue
// Two-entry queue of decoded pairs between front and back.
// ----------------------------------------------------------------------------
module vupd_queue
    import vupd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);
    t_entry r_mem [QDEPTH];
    logic   r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full = r_cnt == 2'(QDEPTH);
    assign o_empty = r_cnt == 2'd0;
    assign o_head = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

[design/vupd_back.sv]
// ----------------------------------------------------------------------------
// vupd_back
// Sends the valid slots of the head entry, one word a cycle while out_ch is not stalled, via output reg.
// ----------------------------------------------------------------------------
module vupd_back
    import vupd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_entry    i_head,
    output logic      o_pop,
    vupd_out_if.source out_ch
);
    logic [2:0] r_sent;
    logic       r_valid;
    t_uop       r_data;
    logic [2:0] rem;
    logic [1:0] sel;
    logic       load, last;

    assign rem = i_head.vld & ~r_sent;
    assign load = !i_empty && (!r_valid || out_ch.ready);
    always_comb begin
        if (rem[0]) sel = 2'd0;
        else if (rem[1]) sel = 2'd1;
        else sel = 2'd2;
    end
    assign last = (rem & ~(3'b001 << sel)) == 3'b000;
    assign o_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sent <= last ? 3'b000 : (r_sent | (3'b001 << sel));
            end else if (out_ch.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_data <= i_head.slot[sel];
    end

    assign out_ch.valid = r_valid;
    assign out_ch.data = r_data;
endmodule

[design/vector_unit_pair_decoder_core.sv]
// ----------------------------------------------------------------------------
// vector_unit_pair_decoder_core
// Decodes VLIW instruction pairs into micro-op words.
// ----------------------------------------------------------------------------
// channel   dir  word
// in_ch     in   upper_word, lower_word, pc
// out_ch    out  one micro-op
// A pair is decoded in the cycle it is accepted and queued (two entries).
// The back end sends one word a cycle from its output register unless out_ch
// stalls, so a pair gives one to three words at the output port. Synchronous
// reset clears block state, queue and output valid. Either side may stall alone.
`include "vector_unit_pair_decoder_core_defines.svh"
module vector_unit_pair_decoder_core
    import vupd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    vupd_in_if.sink    in_ch,
    vupd_out_if.source out_ch
);
    logic   push, pop, full, empty;
    t_entry entry, head;

    vupd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .i_q_full(full), .o_push(push), .o_entry(entry)
    );

    vupd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_entry(entry),
        .i_pop(pop), .o_full(full), .o_empty(empty), .o_head(head)
    );

    vupd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_head(head),
        .o_pop(pop), .out_ch(out_ch)
    );

    `VUPD_ASSERT(a_no_pop_empty, i_clk, i_rst_n, pop |-> !empty, "pop from empty queue")
    `VUPD_ASSERT(a_no_push_full, i_clk, i_rst_n, push |-> !full, "push into full queue")
    `VUPD_ASSERT(a_pop_last, i_clk, i_rst_n, pop |=> out_ch.data.last_of_pair,
        "entry retired without last word")
endmodule

[verif/vector_unit_pair_decoder_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_unit_pair_decoder_core_tb
// Sends instruction pairs with random idling on both channels. A local decoder
// works out the micro-op words of each accepted pair, and every output word is
// checked as a whole word against the oldest pending word.
// ----------------------------------------------------------------------------
module vector_unit_pair_decoder_core_tb;
    import vupd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;
    vupd_in_if  in_ch ();
    vupd_out_if out_ch ();

    vector_unit_pair_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    t_uop uop_queue[$];
    int   mismatches = 0;
    int   cycles = 0;
    bit   in_delay_slot;
    bit   end_flag_seen;
    bit   steady;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input t_uop got, input t_uop want);
        $display("mismatch: %s got %h want %h", what, got, want);
        mismatches++;
    endtask

    function automatic void append_word(ref t_uop q[$], input t_uop x);
        q.insert(q.size(), x);
    endfunction

    // ---------------- decoder ----------------
    function automatic logic [31:0] branch_target(logic [31:0] lw, logic [31:0] pc);
        logic [31:0] off;
        off = {{21{lw[10]}}, lw[10:0]};
        return pc + (off << 3) + 32'd8;
    endfunction

    task automatic decode_pair(input t_pair p);
        t_uop  words[$];
        t_uop  w;
        t_uop  fault_word;
        bit    done;
        bit    branch;
        bit    fault;
        logic [3:0]  fcode;
        logic [6:0]  sel;
        logic [3:0]  d4, s4;
        logic [14:0] imm;
        done = in_delay_slot;
        fault = 1'b0;
        branch = 1'b0;
        fcode = OP_BADOP;
        // upper
        w = '0;
        sel = {p.upper_word[10:6], p.upper_word[1:0]};
        if (p.upper_word[5:0] >= 6'h3C) begin
            if (sel == 7'h2F || sel == 7'h30) begin
            end else if (sel >= 7'h08 && sel <= 7'h0B || sel >= 7'h18 && sel <= 7'h1B) begin
                w.op = (sel >= 7'h18) ? OP_MUL : OP_MADD;
                w.dest_special = DS_ACC;
                append_word(words, w);
            end else fault = 1'b1;
        end else if (p.upper_word[5:0] >= 6'h08 && p.upper_word[5:0] <= 6'h0B) begin
            w.op = OP_MADD;
            w.dest_reg = p.upper_word[10:6];
            append_word(words, w);
        end else if (p.upper_word[5:0] >= 6'h18 && p.upper_word[5:0] <= 6'h1B) begin
            w.op = OP_MUL;
            w.dest_reg = p.upper_word[10:6];
            append_word(words, w);
        end else fault = 1'b1;
        if (words.size() == 1) begin
            words[0].source_value = 32'(p.upper_word[15:11]);
            words[0].source2_value = 16'(p.upper_word[20:16]);
            words[0].broadcast_sel = p.upper_word[1:0];
            words[0].field_mask = p.upper_word[24:21];
        end
        // lower
        if (!fault) begin
            w = '0;
            if (p.upper_word[31]) begin
                w.op = OP_LOADFLOAT;
                w.dest_special = DS_I;
                w.source_value = p.lower_word;
                append_word(words, w);
            end else if (p.lower_word[31]) begin
                sel = {p.lower_word[10:6], p.lower_word[1:0]};
                if (p.lower_word == MOVE_VF0_WORD) begin
                end else if (p.lower_word[5:0] < 6'h3C) fault = 1'b1;
                else if (sel == SP_LQI) begin
                    w.op = OP_LQI;
                    w.dest_reg = p.lower_word[20:16];
                    w.source2_value = 16'(p.lower_word[15:11]);
                end else if (sel == SP_SQI) begin
                    w.op = OP_SQI;
                    w.source_value = 32'(p.lower_word[15:11]);
                    w.source2_value = 16'(p.lower_word[20:16]);
                end else fault = 1'b1;
                if (!fault && p.lower_word != MOVE_VF0_WORD) begin
                    w.field_mask = p.lower_word[24:21];
                    append_word(words, w);
                end
            end else begin
                case (p.lower_word[31:25])
                    LO_IADDIU: begin
                        d4 = p.lower_word[19:16];
                        s4 = p.lower_word[14:11];
                        imm = {p.lower_word[24:21], p.lower_word[10:0]};
                        if (s4 == d4) begin
                            w.op = OP_MOVE;
                            w.source_value = 32'(s4);
                        end else if (s4 == 4'd0) begin
                            w.op = OP_LOADCONST;
                            w.source_value = 32'(imm);
                        end else begin
                            w.op = OP_ADDIMM;
                            w.source_value = 32'(s4);
                        end
                        w.dest_reg = 5'(d4);
                        w.source2_value = 16'(imm);
                        append_word(words, w);
                    end
                    LO_B: begin
                        w.op = OP_JUMP;
                        w.target_addr = branch_target(p.lower_word, p.pc);
                        branch = 1'b1;
                    end
                    LO_BAL: begin
                        w.op = OP_JAL;
                        w.target_addr = branch_target(p.lower_word, p.pc);
                        w.link_value = 29'((p.pc + 32'd16) >> 3);
                        w.dest_reg = 5'(p.lower_word[19:16]);
                        branch = 1'b1;
                    end
                    LO_JR: begin
                        w.op = OP_JR;
                        w.source_value = 32'(p.lower_word[14:11]);
                        branch = 1'b1;
                    end
                    default: fault = 1'b1;
                endcase
                if (branch) begin
                    append_word(words, w);
                    if (in_delay_slot) begin
                        fault = 1'b1;
                        fcode = OP_DELAYFAULT;
                    end else in_delay_slot = 1'b1;
                end
            end
        end
        // end flag
        if (!fault) begin
            if (p.upper_word[30]) begin
                end_flag_seen = 1'b1;
                if (in_delay_slot) begin
                    fault = 1'b1;
                    fcode = OP_DELAYFAULT;
                end else in_delay_slot = 1'b1;
            end else if (end_flag_seen) begin
                w = '0;
                w.op = OP_STOP;
                w.target_addr = p.pc + 32'd8;
                append_word(words, w);
            end
        end
        if (fault) begin
            fault_word = '0;
            fault_word.op = fcode;
            fault_word.last_of_pair = 1'b1;
            fault_word.block_done = 1'b1;
            append_word(uop_queue, fault_word);
            in_delay_slot = 1'b0;
            end_flag_seen = 1'b0;
            return;
        end
        if (words.size() == 0) begin
            w = '0;
            w.op = OP_BUBBLE;
            append_word(words, w);
        end
        foreach (words[k]) begin
            words[k].last_of_pair = (k == words.size() - 1);
            words[k].block_done = done;
            append_word(uop_queue, words[k]);
        end
        if (done) begin
            in_delay_slot = 1'b0;
            end_flag_seen = 1'b0;
        end
    endtask

    // ---------------- driving ----------------
    task automatic send_pair(input logic [31:0] uw, input logic [31:0] lw,
                             input logic [31:0] pc);
        t_pair p;
        p = '{uw, lw, pc};
        while (!steady && $urandom_range(99) < 12) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= p;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        decode_pair(p);
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
        out_ch.ready <= i_rst_n && (steady || $urandom_range(99) >= 12);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (uop_queue.size() == 0) report("unexpected word", out_ch.data, '0);
            else if (out_ch.data !== uop_queue[0]) begin
                report("word", out_ch.data, uop_queue[0]);
                void'(uop_queue.pop_front());
            end else void'(uop_queue.pop_front());
        end
    end

    // ---------------- random word makers ----------------
    function automatic logic [31:0] rand_upper(bit allow_end);
        logic [31:0] uw;
        uw = $urandom;
        case ($urandom_range(4))
            0: uw[5:0] = 6'(32'h08 + $urandom_range(3));
            1: uw[5:0] = 6'(32'h18 + $urandom_range(3));
            2: begin
                uw[5:0] = 6'(32'h3C + $urandom_range(3));
                uw[10:6] = $urandom_range(1) ? 5'(32'h02 + $urandom_range(1)) : 5'h06;
            end
            3: begin
                uw[5:0] = 6'(32'h3C + $urandom_range(3));
                uw[10:6] = 5'h0B;
                uw[1:0] = 2'd3;
            end
            default: ;
        endcase
        uw[31] = ($urandom_range(9) == 0);
        uw[30] = allow_end && ($urandom_range(9) == 0);
        return uw;
    endfunction

    function automatic logic [31:0] rand_lower(bit allow_branch);
        logic [31:0] lw;
        lw = $urandom;
        case ($urandom_range(allow_branch ? 7 : 4))
            0, 1: lw[31:25] = LO_IADDIU;
            2: begin
                lw[31] = 1'b1;
                lw[5:0] = 6'(32'h3C + $urandom_range(3));
                {lw[10:6], lw[1:0]} = $urandom_range(1) ? SP_LQI : SP_SQI;
            end
            3: lw = MOVE_VF0_WORD;
            4: begin
                lw[31:25] = LO_IADDIU;
                lw[14:11] = $urandom_range(1) ? lw[19:16] : 4'd0;
            end
            5: lw[31:25] = LO_B;
            6: lw[31:25] = LO_BAL;
            default: lw[31:25] = LO_JR;
        endcase
        return lw;
    endfunction

    // ---------------- tests ----------------
    localparam logic [31:0] UP_NOP = 32'h0000_02FF;  // acc-form sel 0x2F
    localparam logic [31:0] LO_NOP = MOVE_VF0_WORD;

    task automatic test_directed();
        send_pair(UP_NOP, LO_NOP, 32'h0);                       // empty pair
        send_pair(32'hFFE0_F808 & 32'hBFFF_FFFF, 32'h11FF_FFFF, 32'hFFFF_FFF8);
        send_pair(32'h01FF_F81B, {LO_IADDIU, 4'hF, 4'h3, 1'b0, 4'h3, 11'h7FF}, 32'h10);
        send_pair(32'h0000_02FC | 32'h3, {LO_IADDIU, 25'h0_0_1_0_5AA}, 32'h20); // loadconst
        send_pair(32'h0000_00BC, 32'h81FF_FB7C, 32'h28);        // acc madd, lqi
        send_pair(32'h0000_06BF, 32'h8000_037D, 32'h30);        // bad acc upper, sqi
        send_pair(32'h8000_02FF, 32'hFFFF_FFFF, 32'h38);        // load float
        send_pair(UP_NOP, {LO_B, 25'h400}, 32'h40);             // back branch
        send_pair(UP_NOP, LO_NOP, 32'h48);                      // delay slot ends
        send_pair(UP_NOP, {LO_BAL, 25'h3_F3FF}, 32'hFFFF_FFF0); // wrap
        send_pair(UP_NOP, {LO_JR, 25'h7800}, 32'h58);           // branch in slot
        send_pair(UP_NOP, {LO_JR, 25'h7800}, 32'h60);
        send_pair(32'h4000_02FF, LO_NOP, 32'h68);               // end flag in slot
        send_pair(32'h4000_02FF, {LO_B, 25'h1}, 32'h70);        // branch + end
        send_pair(32'h4000_02FF, LO_NOP, 32'h78);               // end flag
        send_pair(UP_NOP, {LO_IADDIU, 25'h1_2_0_0_123}, 32'h80); // stop + done
        send_pair(32'h0000_0000, LO_NOP, 32'h88);               // bad upper
        send_pair(UP_NOP, 32'h7E00_0000, 32'h90);               // bad lower
        send_pair(UP_NOP, 32'h8000_003B, 32'h98);               // special too low
        send_pair(UP_NOP, 32'h8000_00FC, 32'hA0);               // bad special
        send_pair(32'h0000_007D, LO_NOP, 32'hA8);               // bad acc upper
    endtask

    task automatic test_random_blocks(input int n);
        logic [31:0] pc;
        pc = $urandom;
        for (int i = 0; i < n; i++) begin
            if (i == n / 3) steady = 1'b1;
            if (i == n / 2) steady = 1'b0;
            if ($urandom_range(9) == 0)
                send_pair($urandom, $urandom, $urandom);
            else
                send_pair(rand_upper($urandom_range(3) == 0),
                          rand_lower($urandom_range(2) == 0), pc);
            pc = pc + 32'd8;
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        steady       = 1'b0;
        in_delay_slot = 1'b0;
        end_flag_seen = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_blocks(180);
        in_ch.valid <= 1'b0;
        while (uop_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && uop_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+design
design/vupd_pkg.sv
design/vupd_if.sv
design/vupd_front.sv
design/vupd_queue.sv
design/vupd_back.sv
design/vector_unit_pair_decoder_core.sv
verif/vector_unit_pair_decoder_core_tb.sv
